// ===== rtl/core/sacl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_pkg: shared types and constants
// Field widths, register map and controller command bundle for the
// set-associative LRU tag store.
// ---------------------------------------------------------------------------
package sacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int AGE_W     = 3;
    localparam int WAY_OUT_W = 3;
    localparam int CFG_SET_W = 4;
    localparam int CFG_WAY_W = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // register map: one register per word, selected by paddr[2]
    localparam logic REG_SET_COUNT = 1'b0;
    localparam logic REG_WAY_COUNT = 1'b1;

    localparam logic [CFG_SET_W-1:0] SET_COUNT_RESET = 4'd4;
    localparam logic [CFG_WAY_W-1:0] WAY_COUNT_RESET = 2'd0;

    typedef struct packed {
        logic [CFG_SET_W-1:0] set_count_log2;
        logic [CFG_WAY_W-1:0] way_count_log2;
    } sacl_cfg_t;

    typedef struct packed {
        logic capture;  // accept a beat, read its set
        logic commit;   // write back the set and post the result
        logic clear;    // zero the ages and valid bits of one row during the post-reset sweep
    } sacl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/sacl_regs.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_regs: configuration registers
// APB-style write/read access to set_count_log2 and way_count_log2.
// ---------------------------------------------------------------------------
module sacl_regs
    import sacl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output sacl_cfg_t               cfg
);

    logic [CFG_SET_W-1:0] set_count_reg;
    logic [CFG_WAY_W-1:0] way_count_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg <= SET_COUNT_RESET;
            way_count_reg <= WAY_COUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[PADDR_W-1])
                REG_SET_COUNT: set_count_reg <= pwdata[CFG_SET_W-1:0];
                REG_WAY_COUNT: way_count_reg <= pwdata[CFG_WAY_W-1:0];
                default:       set_count_reg <= set_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1])
            REG_SET_COUNT: prdata = PDATA_W'(set_count_reg);
            REG_WAY_COUNT: prdata = PDATA_W'(way_count_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.set_count_log2 = set_count_reg;
    assign cfg.way_count_log2 = way_count_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sacl_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_ctrl: access sequencer
// Sweeps the set memory clear after reset, then runs each access as a
// read cycle followed by a write-back cycle.
// ---------------------------------------------------------------------------
module sacl_ctrl
    import sacl_pkg::*;
#(
    parameter  int MAX_SETS = 512,
    localparam int SMAX     = $clog2(MAX_SETS + 1) - 1,
    localparam int ROW_W    = (SMAX > 0) ? SMAX : 1,
    localparam int ROWS     = 1 << SMAX
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output sacl_cmd_t             cmd,
    output logic      [ROW_W-1:0] clr_row
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    state_t           state_reg;
    logic             busy_reg;
    logic [ROW_W-1:0] row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            row_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (row_reg == LAST_ROW)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_LOOKUP;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_LOOKUP:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                    busy_reg  <= 1'b1;
                    row_reg   <= '0;
                end
            endcase
        end
    end

    assign busy        = busy_reg;
    assign clr_row     = row_reg;
    assign cmd.capture = start && !busy_reg;
    assign cmd.commit  = (state_reg == ST_LOOKUP);
    assign cmd.clear   = (state_reg == ST_CLEAR);

endmodule
`default_nettype wire

// ===== rtl/core/sacl_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_dpath: tag, age and valid storage with lookup logic
// One row per set holds every way; a lookup reads the row, picks the hit
// or victim way, updates ages and writes the row back.
// ---------------------------------------------------------------------------
module sacl_dpath
    import sacl_pkg::*;
#(
    parameter  int MAX_SETS         = 512,
    parameter  int MAX_WAYS         = 8,
    parameter  int LINE_OFFSET_BITS = 6,
    localparam int SMAX             = $clog2(MAX_SETS + 1) - 1,
    localparam int ROW_W            = (SMAX > 0) ? SMAX : 1,
    localparam int ROWS             = 1 << SMAX
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sacl_cmd_t            cmd,
    input  wire logic     [ROW_W-1:0] clr_row,
    input  wire sacl_cfg_t            cfg,
    input  wire logic    [ADDR_W-1:0] address,
    output logic                      done,
    output logic                      hit,
    output logic      [WAY_OUT_W-1:0] way_used,
    output logic          [CNT_W-1:0] access_count,
    output logic          [CNT_W-1:0] miss_count
);

    localparam int TAG_W = ADDR_W - LINE_OFFSET_BITS;
    localparam int WMAX  = $clog2(MAX_WAYS + 1) - 1;
    localparam int WAY_W = (WMAX > 0) ? WMAX : 1;
    localparam int NWAYS = 1 << WMAX;
    localparam int LIM_W = WMAX + 1;

    // set memories, one row per set
    logic [NWAYS*TAG_W-1:0] tag_mem [ROWS];
    logic [NWAYS*AGE_W-1:0] age_mem [ROWS];
    logic [NWAYS-1:0]       vld_mem [ROWS];

    logic [NWAYS*TAG_W-1:0] tag_rd_reg;
    logic [NWAYS*AGE_W-1:0] age_rd_reg;
    logic [NWAYS-1:0]       vld_rd_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [LIM_W-1:0]       way_lim_reg;

    logic [CFG_SET_W-1:0]   sbits_eff;
    logic [CFG_WAY_W-1:0]   wbits_eff;
    logic [ROW_W-1:0]       set_mask;
    logic [ROW_W-1:0]       row_in;
    logic [TAG_W-1:0]       tag_in;

    logic [NWAYS-1:0]       in_use;
    logic [NWAYS-1:0]       match;
    logic [NWAYS-1:0]       inv;
    logic                   hit_found;
    logic                   inv_found;
    logic [WAY_W-1:0]       hit_way;
    logic [WAY_W-1:0]       inv_way;
    logic [WAY_W-1:0]       old_way;
    logic [WAY_W-1:0]       used_way;
    logic [AGE_W-1:0]       best_age;
    logic [AGE_W-1:0]       hit_age;
    logic [AGE_W-1:0]       age_old [NWAYS];
    logic                   aged;
    logic [NWAYS*TAG_W-1:0] tag_row_next;
    logic [NWAYS*AGE_W-1:0] age_row_next;
    logic [NWAYS-1:0]       vld_row_next;

    logic                   done_reg;
    logic [CNT_W-1:0]       access_count_reg;
    logic [CNT_W-1:0]       miss_count_reg;
    logic                   hit_reg;
    logic [WAY_OUT_W-1:0]   way_used_reg;

    // clamp configuration to what the storage supports
    always_comb
    begin
        sbits_eff = (int'(cfg.set_count_log2) > SMAX) ? CFG_SET_W'(SMAX)
                                                      : cfg.set_count_log2;
        wbits_eff = (int'(cfg.way_count_log2) > WMAX) ? CFG_WAY_W'(WMAX)
                                                      : cfg.way_count_log2;
        set_mask  = ~({ROW_W{1'b1}} << sbits_eff);
        row_in    = address[LINE_OFFSET_BITS +: ROW_W] & set_mask;
        tag_in    = TAG_W'(address >> (int'(sbits_eff) + LINE_OFFSET_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_rd_reg  <= tag_mem[row_in];
            age_rd_reg  <= age_mem[row_in];
            vld_rd_reg  <= vld_mem[row_in];
            row_reg     <= row_in;
            tag_reg     <= tag_in;
            way_lim_reg <= LIM_W'(1) << wbits_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            age_mem[clr_row] <= '0;
            vld_mem[clr_row] <= '0;
        end
        else if (cmd.commit)
        begin
            age_mem[row_reg] <= age_row_next;
            vld_mem[row_reg] <= vld_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_found)
        begin
            tag_mem[row_reg] <= tag_row_next;
        end
    end

    // lookup, victim choice and age update
    always_comb
    begin
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        for (int w = 0; w < NWAYS; w++)
        begin
            in_use[w]  = LIM_W'(w) < way_lim_reg;
            age_old[w] = age_rd_reg[w*AGE_W +: AGE_W];
            match[w]   = in_use[w] && vld_rd_reg[w] &&
                         (tag_rd_reg[w*TAG_W +: TAG_W] == tag_reg);
            inv[w]     = in_use[w] && !vld_rd_reg[w];
        end
        // scan downward so the lowest way wins
        for (int w = NWAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (inv[w])
            begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
        // oldest way, first one on a tie
        old_way  = '0;
        best_age = age_old[0];
        for (int w = 1; w < NWAYS; w++)
        begin
            if (in_use[w] && (age_old[w] > best_age))
            begin
                best_age = age_old[w];
                old_way  = WAY_W'(w);
            end
        end
        priority if (hit_found)
            used_way = hit_way;
        else if (inv_found)
            used_way = inv_way;
        else
            used_way = old_way;
        hit_age = age_old[hit_way];

        tag_row_next = tag_rd_reg;
        for (int w = 0; w < NWAYS; w++)
        begin
            if (hit_found)
                aged = in_use[w] && (age_old[w] < hit_age);
            else
                aged = in_use[w] && (!inv_found || (WAY_W'(w) < inv_way));
            if (WAY_W'(w) == used_way)
            begin
                age_row_next[w*AGE_W +: AGE_W] = '0;
                tag_row_next[w*TAG_W +: TAG_W] = tag_reg;
            end
            else if (aged && (age_old[w] != AGE_MAX))
                age_row_next[w*AGE_W +: AGE_W] = age_old[w] + 1'b1;
            else
                age_row_next[w*AGE_W +: AGE_W] = age_old[w];
        end
        vld_row_next = vld_rd_reg | (NWAYS'(1) << used_way);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            access_count_reg <= '0;
            miss_count_reg   <= '0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                if (access_count_reg != '1)
                    access_count_reg <= access_count_reg + CNT_W'(1);
                if (!hit_found && (miss_count_reg != '1))
                    miss_count_reg <= miss_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg      <= hit_found;
            way_used_reg <= WAY_OUT_W'(used_way);
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign way_used     = way_used_reg;
    assign access_count = access_count_reg;
    assign miss_count   = miss_count_reg;

endmodule
`default_nettype wire

// ===== rtl/core/set_assoc_cache_lru_tags.sv =====
`default_nettype none
// done is registered in the write-back state entered on accepting start.
// Accesses do not overlap: each is a read and then a write-back on the
// single-port set memory; busy is high during the write-back.
// Reset: busy stays high while all 2**floor(log2(MAX_SETS)) rows (512 by
// default) have their valid bits and ages swept to zero; config writes work
// meanwhile. Results cannot be stalled: done marks one cycle of valid outputs.
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_tags: set-associative tag store with LRU ages
// Looks up each address, reports hit and way, fills or evicts on a miss and
// keeps saturating access and miss counts.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_tags
    import sacl_pkg::*;
#(
    parameter int MAX_SETS         = 512,
    parameter int MAX_WAYS         = 8,
    parameter int LINE_OFFSET_BITS = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic    [ADDR_W-1:0] address,
    output logic                      done,
    output logic                      hit,
    output logic      [WAY_OUT_W-1:0] way_used,
    output logic          [CNT_W-1:0] access_count,
    output logic          [CNT_W-1:0] miss_count,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic   [PADDR_W-1:0] paddr,
    input  wire logic   [PDATA_W-1:0] pwdata,
    output logic        [PDATA_W-1:0] prdata,
    output logic                      pready
);

    localparam int SMAX  = $clog2(MAX_SETS + 1) - 1;
    localparam int ROW_W = (SMAX > 0) ? SMAX : 1;

    sacl_cfg_t        cfg;
    sacl_cmd_t        cmd;
    logic [ROW_W-1:0] clr_row;

    sacl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sacl_ctrl #(
        .MAX_SETS (MAX_SETS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .clr_row (clr_row)
    );

    sacl_dpath #(
        .MAX_SETS         (MAX_SETS),
        .MAX_WAYS         (MAX_WAYS),
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .clr_row      (clr_row),
        .cfg          (cfg),
        .address      (address),
        .done         (done),
        .hit          (hit),
        .way_used     (way_used),
        .access_count (access_count),
        .miss_count   (miss_count)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sacl_chk.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_chk: port-level checks
// Watches the command handshake and the result counters of the tag store.
// ---------------------------------------------------------------------------
module sacl_chk
    import sacl_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic             hit,
    input wire logic [CNT_W-1:0] miss_count
);

    // every accepted beat yields a result via the write-back state and done register
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("no result two cycles after accepted beat");

    // no result without an accepted beat
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without accepted beat");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after accepted beat");

    // hits leave the miss count alone, misses bump it unless saturated
    a_miss_count_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (miss_count == $past(miss_count)))
        else $error("miss count moved on a hit");

    a_miss_count_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> ((miss_count == $past(miss_count) + CNT_W'(1)) ||
                            ((miss_count == '1) && ($past(miss_count) == '1))))
        else $error("miss count not advanced on a miss");

endmodule

bind set_assoc_cache_lru_tags sacl_chk u_sacl_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .hit        (hit),
    .miss_count (miss_count)
);
`default_nettype wire
